// ----- sv/bfs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfs_pkg
// Shared sizes, command codes, register indexes and sequencer states for the
// breadth-first search core.
// ----------------------------------------------------------------------------
package bfs_pkg;

  localparam int MAX_V      = 1024;
  localparam int MAX_E      = 4096;
  localparam int VW         = $clog2(MAX_V);       // vertex id
  localparam int CW         = $clog2(MAX_V) + 1;   // vertex count, queue pointers
  localparam int OAW        = $clog2(MAX_V + 1);   // offset table address
  localparam int EAW        = $clog2(MAX_E);       // adjacency address
  localparam int FW         = 13;                  // index and value fields
  localparam int DW         = 16;                  // distance and parent
  localparam int CFG_DW     = 11;
  localparam int CFG_AW     = 1;

  localparam logic [DW-1:0] NONE16 = '1;

  typedef enum logic [1:0] {
    CMD_WR_OFFSET = 2'd0,
    CMD_WR_ADJ    = 2'd1,
    CMD_RUN       = 2'd2,
    CMD_READ      = 2'd3
  } cmd_t;

  localparam logic [CFG_AW-1:0] REG_VERTEX_COUNT  = 1'd0;
  localparam logic [CFG_AW-1:0] REG_SOURCE_VERTEX = 1'd1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_INIT, S_POP, S_VTX, S_LO, S_HI,
    S_EDGE, S_NBR, S_CHK, S_DONE
  } state_t;

endpackage

// ----- sv/bfs_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfs_in_if
// Command channel: valid/ready handshake with command, index and value.
// ----------------------------------------------------------------------------
interface bfs_in_if;
  import bfs_pkg::*;
  logic          valid;
  logic          ready;
  logic [1:0]    cmd;
  logic [FW-1:0] index;
  logic [FW-1:0] value;
  modport source (output valid, cmd, index, value, input ready);
  modport sink   (input valid, cmd, index, value, output ready);
endinterface

// ----- sv/bfs_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfs_out_if
// Result channel: valid/ready handshake with status, distance and parent.
// ----------------------------------------------------------------------------
interface bfs_out_if;
  import bfs_pkg::*;
  logic          valid;
  logic          ready;
  logic          status;
  logic [DW-1:0] distance;
  logic [DW-1:0] parent;
  modport source (output valid, status, distance, parent, input ready);
  modport sink   (input valid, status, distance, parent, output ready);
endinterface

// ----- sv/bfs_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bfs_ram #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/bfs_csr_graph_distances_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfs_csr_graph_distances_core
// Breadth-first search over a CSR graph with a frontier queue in RAM.
// ----------------------------------------------------------------------------
// Offset and adjacency writes can stream back to back while each result is
// taken. A vertex read in range passes through S_READ; an out-of-range index
// is answered directly. A run first sweeps the 1024-entry result RAM, one
// entry per cycle, then walks the graph through a single sequencer: S_POP,
// S_VTX, S_LO, S_HI and a closing S_EDGE per dequeued vertex, plus S_EDGE and
// S_NBR per edge and S_CHK per edge whose neighbour is in range, bounded by the
// single read port of the result RAM; S_INIT seeds the queue, S_POP finds it
// empty and S_DONE answers. The same clearing sweep runs after reset, during
// which no item is accepted. Configuration writes are taken in any cycle.
module bfs_csr_graph_distances_core (
  input  logic                          clk,
  input  logic                          rst_n,
  bfs_in_if.sink                        in_bus,
  bfs_out_if.source                     out_bus,
  input  logic                          cfg_we,
  input  logic [bfs_pkg::CFG_AW-1:0]    cfg_index,
  input  logic [bfs_pkg::CFG_DW-1:0]    cfg_wdata
);
  import bfs_pkg::*;

  state_t state_r, state_nxt;

  logic [CW-1:0]   vcount_r;
  logic [VW-1:0]   src_r;
  logic [VW-1:0]   clr_r, clr_nxt;
  logic            run_r, run_nxt;
  logic            run_bad_r, run_bad_nxt;
  logic [CW-1:0]   head_r, head_nxt, tail_r, tail_nxt;
  logic [VW-1:0]   v_r, v_nxt, w_r, w_nxt;
  logic [DW-1:0]   dv_r, dv_nxt;
  logic [FW-1:0]   e_r, e_nxt, hi_r, hi_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_status_r, out_status_nxt;
  logic [DW-1:0]   out_dist_r, out_dist_nxt, out_par_r, out_par_nxt;

  logic [CW-1:0]   n_eff;
  logic            in_acc;

  // Memory ports
  logic            off_we;
  logic [OAW-1:0]  off_waddr, off_raddr;
  logic [FW-1:0]   off_rdata;
  logic            adj_we;
  logic [EAW-1:0]  adj_waddr, adj_raddr;
  logic [FW-1:0]   adj_rdata;
  logic            q_we;
  logic [VW-1:0]   q_waddr, q_wdata, q_raddr, q_rdata;
  logic            res_we;
  logic [VW-1:0]   res_waddr, res_raddr;
  logic [2*DW-1:0] res_wdata, res_rdata;

  bfs_ram #(.DATA_W(FW), .DEPTH(MAX_V + 1)) u_off (
    .clk(clk), .we(off_we), .waddr(off_waddr), .wdata(in_bus.value),
    .raddr(off_raddr), .rdata(off_rdata)
  );
  bfs_ram #(.DATA_W(FW), .DEPTH(MAX_E)) u_adj (
    .clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(in_bus.value),
    .raddr(adj_raddr), .rdata(adj_rdata)
  );
  bfs_ram #(.DATA_W(VW), .DEPTH(MAX_V)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );
  // Each entry holds {distance, parent}; a parent of all ones marks unvisited.
  bfs_ram #(.DATA_W(2 * DW), .DEPTH(MAX_V)) u_res (
    .clk(clk), .we(res_we), .waddr(res_waddr), .wdata(res_wdata),
    .raddr(res_raddr), .rdata(res_rdata)
  );

  assign n_eff = (vcount_r > CW'(MAX_V)) ? CW'(MAX_V) : vcount_r;
  assign in_bus.ready = (state_r == S_IDLE) && (!out_valid_r || out_bus.ready);
  assign in_acc = in_bus.valid && in_bus.ready;

  assign out_bus.valid    = out_valid_r;
  assign out_bus.status   = out_status_r;
  assign out_bus.distance = out_dist_r;
  assign out_bus.parent   = out_par_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_r == VW'(MAX_V - 1)) begin
          if (!run_r)         state_nxt = S_IDLE;
          else if (run_bad_r) state_nxt = S_DONE;
          else                state_nxt = S_INIT;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          unique case (cmd_t'(in_bus.cmd))
            CMD_RUN:  state_nxt = S_CLEAR;
            CMD_READ: state_nxt = (in_bus.index < FW'(n_eff)) ? S_READ : S_IDLE;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_READ: state_nxt = S_IDLE;
      S_INIT: state_nxt = S_POP;
      S_POP:  state_nxt = (head_r < tail_r) ? S_VTX : S_DONE;
      S_VTX:  state_nxt = S_LO;
      S_LO:   state_nxt = S_HI;
      S_HI:   state_nxt = S_EDGE;
      S_EDGE: state_nxt = (e_r < hi_r) ? S_NBR : S_POP;
      S_NBR:  state_nxt = (adj_rdata < FW'(n_eff)) ? S_CHK : S_EDGE;
      S_CHK:  state_nxt = S_EDGE;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    clr_nxt        = clr_r;
    run_nxt        = run_r;
    run_bad_nxt    = run_bad_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    v_nxt          = v_r;
    w_nxt          = w_r;
    dv_nxt         = dv_r;
    e_nxt          = e_r;
    hi_nxt         = hi_r;
    out_valid_nxt  = out_valid_r && !out_bus.ready;
    out_status_nxt = out_status_r;
    out_dist_nxt   = out_dist_r;
    out_par_nxt    = out_par_r;

    off_we    = 1'b0;
    off_waddr = in_bus.index[OAW-1:0];
    off_raddr = {1'b0, q_rdata};
    adj_we    = 1'b0;
    adj_waddr = in_bus.index[EAW-1:0];
    adj_raddr = e_r[EAW-1:0];
    q_we      = 1'b0;
    q_waddr   = tail_r[VW-1:0];
    q_wdata   = w_r;
    q_raddr   = head_r[VW-1:0];
    res_we    = 1'b0;
    res_waddr = w_r;
    res_wdata = {dv_r + DW'(1), DW'(v_r)};
    res_raddr = in_bus.index[VW-1:0];

    unique case (state_r)
      S_CLEAR: begin
        res_we    = 1'b1;
        res_waddr = clr_r;
        res_wdata = {NONE16, NONE16};
        clr_nxt   = clr_r + VW'(1);
      end
      S_IDLE: begin
        if (in_acc) begin
          unique case (cmd_t'(in_bus.cmd))
            CMD_WR_OFFSET: begin
              off_we         = (in_bus.index <= FW'(MAX_V));
              out_valid_nxt  = 1'b1;
              out_status_nxt = !off_we;
              out_dist_nxt   = '0;
              out_par_nxt    = '0;
            end
            CMD_WR_ADJ: begin
              adj_we         = (in_bus.index < FW'(MAX_E));
              out_valid_nxt  = 1'b1;
              out_status_nxt = !adj_we;
              out_dist_nxt   = '0;
              out_par_nxt    = '0;
            end
            CMD_RUN: begin
              run_nxt     = 1'b1;
              run_bad_nxt = (n_eff == '0) || ({1'b0, src_r} >= n_eff);
              clr_nxt     = '0;
            end
            default: begin
              if (in_bus.index >= FW'(n_eff)) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = 1'b1;
                out_dist_nxt   = NONE16;
                out_par_nxt    = NONE16;
              end
            end
          endcase
        end
      end
      S_READ: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = 1'b0;
        out_dist_nxt   = res_rdata[2*DW-1:DW];
        out_par_nxt    = res_rdata[DW-1:0];
      end
      S_INIT: begin
        res_we    = 1'b1;
        res_waddr = src_r;
        res_wdata = {DW'(0), DW'(src_r)};
        q_we      = 1'b1;
        q_waddr   = '0;
        q_wdata   = src_r;
        head_nxt  = '0;
        tail_nxt  = CW'(1);
      end
      S_POP: begin
        if (head_r < tail_r) begin
          head_nxt = head_r + CW'(1);
        end
      end
      S_VTX: begin
        v_nxt     = q_rdata;
        off_raddr = {1'b0, q_rdata};
        res_raddr = q_rdata;
      end
      S_LO: begin
        e_nxt     = off_rdata;
        dv_nxt    = res_rdata[2*DW-1:DW];
        off_raddr = OAW'(v_r) + OAW'(1);
      end
      S_HI: begin
        hi_nxt = (off_rdata > FW'(MAX_E)) ? FW'(MAX_E) : off_rdata;
      end
      S_EDGE: begin
        adj_raddr = e_r[EAW-1:0];
      end
      S_NBR: begin
        w_nxt     = adj_rdata[VW-1:0];
        res_raddr = adj_rdata[VW-1:0];
        if (adj_rdata >= FW'(n_eff)) begin
          e_nxt = e_r + FW'(1);
        end
      end
      S_CHK: begin
        e_nxt = e_r + FW'(1);
        if (res_rdata[DW-1:0] == NONE16) begin
          res_we = 1'b1;
          if (tail_r < CW'(MAX_V)) begin
            q_we     = 1'b1;
            tail_nxt = tail_r + CW'(1);
          end
        end
      end
      S_DONE: begin
        run_nxt        = 1'b0;
        out_valid_nxt  = 1'b1;
        out_status_nxt = run_bad_r;
        out_dist_nxt   = '0;
        out_par_nxt    = '0;
      end
      default: begin
        run_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      run_r       <= 1'b0;
      run_bad_r   <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
      vcount_r    <= CW'(1);
      src_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      run_r       <= run_nxt;
      run_bad_r   <= run_bad_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_VERTEX_COUNT:  vcount_r <= cfg_wdata[CW-1:0];
          REG_SOURCE_VERTEX: src_r    <= cfg_wdata[VW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    v_r          <= v_nxt;
    w_r          <= w_nxt;
    dv_r         <= dv_nxt;
    e_r          <= e_nxt;
    hi_r         <= hi_nxt;
    out_status_r <= out_status_nxt;
    out_dist_r   <= out_dist_nxt;
    out_par_r    <= out_par_nxt;
  end

endmodule

// ----- sv/bfs_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfs_chk
// Port-level checks for the breadth-first search core, bound to the top level.
// ----------------------------------------------------------------------------
module bfs_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_cmd,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_status,
  input logic [15:0] out_distance,
  input logic [15:0] out_parent
);
  import bfs_pkg::*;

  // A result that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_distance) && $stable(out_parent))
    else $error("result changed while stalled");

  // A run occupies the block, so no further item is taken right after it.
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_cmd == CMD_RUN) |=> !in_ready)
    else $error("item accepted right after a run started");

  // Table writes answer in the very next cycle.
  a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && ((in_cmd == CMD_WR_OFFSET) || (in_cmd == CMD_WR_ADJ))
    |=> out_valid)
    else $error("table write gave no result");

  // An unreached vertex has no parent, and a reached one has one.
  a_unreached: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_status |-> ((out_distance == NONE16) == (out_parent == NONE16)))
    else $error("distance and parent disagree on reachability");

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind bfs_csr_graph_distances_core bfs_chk u_bfs_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_bus.valid), .in_ready(in_bus.ready), .in_cmd(in_bus.cmd),
  .out_valid(out_bus.valid), .out_ready(out_bus.ready), .out_status(out_bus.status),
  .out_distance(out_bus.distance), .out_parent(out_bus.parent)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BFS core testbench
// Loads CSR graphs of several sizes, runs searches from in-range and
// out-of-range sources and reads back vertex results. A behavioral
// search model predicts each reply, and a monitor checks replies in order
// while both sides of the handshake idle at random.
// ----------------------------------------------------------------------------
module testbench;
  import bfs_pkg::*;

  typedef struct {
    cmd_t        cmd;
    logic [12:0] index;
    logic [12:0] value;
  } command_t;

  typedef struct {
    logic        status;
    logic [15:0] distance;
    logic [15:0] parent;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [CFG_AW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_wdata;

  bfs_in_if  in_bus ();
  bfs_out_if out_bus ();

  bfs_csr_graph_distances_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  command_t pending_cmds [$];
  reply_t   expected_replies [$];
  command_t cur_cmd;
  int errors = 0;
  int replies_seen = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;

  // Search model state.
  logic [12:0] m_off  [0:MAX_V];
  logic [12:0] m_adj  [0:MAX_E-1];
  bit          m_seen [0:MAX_V-1];
  logic [15:0] m_dist [0:MAX_V-1];
  logic [15:0] m_par  [0:MAX_V-1];
  int m_vc = 1;
  int m_src = 0;

  // Generator shadow: which table entries hold defined data.
  int g_off    [0:MAX_V];
  bit g_off_ok [0:MAX_V];
  bit g_adj_ok [0:MAX_E-1];

  function automatic int live_count(int vc);
    return (vc < MAX_V) ? vc : MAX_V;
  endfunction

  function automatic bit bfs_walk();
    int n, head, tail, v, lo, hi, w;
    int fq [MAX_V];
    n = live_count(m_vc);
    for (int i = 0; i < MAX_V; i++) begin
      m_seen[i] = 1'b0;
      m_dist[i] = NONE16;
      m_par[i]  = NONE16;
    end
    if (n == 0 || m_src >= n) return 1'b0;
    m_seen[m_src] = 1'b1;
    m_dist[m_src] = '0;
    m_par[m_src]  = 16'(m_src);
    fq[0] = m_src;
    head = 0;
    tail = 1;
    while (head < tail && head < MAX_V) begin
      v = fq[head];
      head++;
      lo = m_off[v];
      hi = m_off[v + 1];
      if (hi > MAX_E) hi = MAX_E;
      for (int e = lo; e < hi; e++) begin
        w = m_adj[e];
        if (w >= n || m_seen[w]) continue;
        m_seen[w] = 1'b1;
        m_dist[w] = m_dist[v] + 16'd1;
        m_par[w]  = 16'(v);
        if (tail < MAX_V) begin
          fq[tail] = w;
          tail++;
        end
      end
    end
    return 1'b1;
  endfunction

  function automatic reply_t search_and_answer(command_t c);
    reply_t r;
    r = '{status: 1'b0, distance: '0, parent: '0};
    case (c.cmd)
      CMD_WR_OFFSET: begin
        if (c.index <= MAX_V) m_off[c.index] = c.value;
        else r.status = 1'b1;
      end
      CMD_WR_ADJ: begin
        if (c.index < MAX_E) m_adj[c.index] = c.value;
        else r.status = 1'b1;
      end
      CMD_RUN: r.status = !bfs_walk();
      default: begin
        if (c.index < live_count(m_vc)) begin
          r.distance = m_dist[c.index];
          r.parent   = m_par[c.index];
        end else begin
          r = '{status: 1'b1, distance: NONE16, parent: NONE16};
        end
      end
    endcase
    return r;
  endfunction

  task automatic put(cmd_t c, int idx, int val);
    command_t item;
    item.cmd = c;
    item.index = 13'(idx);
    item.value = 13'(val);
    pending_cmds.push_back(item);
    if (c == CMD_WR_OFFSET && idx <= MAX_V) begin
      g_off[idx] = val;
      g_off_ok[idx] = 1'b1;
    end else if (c == CMD_WR_ADJ && idx < MAX_E) begin
      g_adj_ok[idx] = 1'b1;
    end
  endtask

  function automatic int pick_nbr(int n);
    if (n > 0 && $urandom_range(0, 99) < 85) return $urandom_range(0, n - 1);
    return $urandom_range(0, 8191);
  endfunction

  // Neighbours inside [first, n), or out of range altogether.
  function automatic int pick_span(int first, int n);
    if ($urandom_range(0, 99) < 85) return $urandom_range(first, n - 1);
    return $urandom_range(n, 8191);
  endfunction

  // Makes sure a run reads only table entries that were written, then issues
  // the run; an edge range with too many holes is cut to empty instead of filled.
  task automatic prep_run(int n);
    int lo, hi, missing;
    for (int v = 0; v <= n && v <= MAX_V; v++) begin
      if (!g_off_ok[v]) put(CMD_WR_OFFSET, v, (v == 0) ? 0 : g_off[v - 1]);
    end
    for (int v = 0; v < n; v++) begin
      lo = g_off[v];
      hi = (g_off[v + 1] > MAX_E) ? MAX_E : g_off[v + 1];
      missing = 0;
      for (int e = lo; e < hi; e++) if (!g_adj_ok[e]) missing++;
      if (missing > 24) begin
        put(CMD_WR_OFFSET, v + 1, lo);
      end else begin
        for (int e = lo; e < hi; e++) if (!g_adj_ok[e]) put(CMD_WR_ADJ, e, pick_nbr(n));
      end
    end
    put(CMD_RUN, $urandom_range(0, 8191), $urandom_range(0, 8191));
  endtask

  task automatic build_graph(int n, int base);
    int off, hi;
    off = base;
    for (int v = 0; v <= n; v++) begin
      put(CMD_WR_OFFSET, v, off);
      off += (n > 100) ? $urandom_range(0, 2) : $urandom_range(0, 4);
    end
    for (int v = 0; v < n; v++) begin
      hi = (g_off[v + 1] > MAX_E) ? MAX_E : g_off[v + 1];
      for (int e = g_off[v]; e < hi; e++) put(CMD_WR_ADJ, e, pick_nbr(n));
    end
  endtask

  // Loads only vertices first..n-1; their edges never lead below first.
  task automatic build_span(int first, int n, int base);
    int off, hi;
    off = base;
    for (int v = first; v <= n; v++) begin
      put(CMD_WR_OFFSET, v, off);
      off += $urandom_range(0, 4);
    end
    for (int v = first; v < n; v++) begin
      hi = (g_off[v + 1] > MAX_E) ? MAX_E : g_off[v + 1];
      for (int e = g_off[v]; e < hi; e++) put(CMD_WR_ADJ, e, pick_span(first, n));
    end
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || expected_replies.size() != 0 || in_bus.valid);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_regs(int vc, int src);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_VERTEX_COUNT;
    cfg_wdata <= CFG_DW'(vc);
    @(posedge clk);
    cfg_index <= REG_SOURCE_VERTEX;
    cfg_wdata <= CFG_DW'(src);
    @(posedge clk);
    cfg_we <= 1'b0;
    m_vc  = vc;
    m_src = src;
    @(posedge clk);
  endtask

  // Driver: one item from the queue per handshake, with a random gap after it.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        expected_replies.push_back(search_and_answer(cur_cmd));
      end
      if (!(in_bus.valid && !in_bus.ready)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_bus.valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          cur_cmd = pending_cmds.pop_front();
          in_bus.cmd   <= cur_cmd.cmd;
          in_bus.index <= cur_cmd.index;
          in_bus.value <= cur_cmd.value;
          in_bus.valid <= 1'b1;
          send_gap = quiet ? 0 : $urandom_range(0, 19);
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each reply against the oldest prediction.
  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_replies.size() == 0) begin
          errors++;
          $display("%0t: unexpected reply status=%0d distance=%0d parent=%0d", $time,
                   out_bus.status, out_bus.distance, out_bus.parent);
        end else begin
          want = expected_replies.pop_front();
          if (out_bus.status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     out_bus.status);
          end
          if (out_bus.distance !== want.distance) begin
            errors++;
            $display("%0t: distance expected %0d actual %0d", $time, want.distance,
                     out_bus.distance);
          end
          if (out_bus.parent !== want.parent) begin
            errors++;
            $display("%0t: parent expected %0d actual %0d", $time, want.parent,
                     out_bus.parent);
          end
        end
        replies_seen++;
        recv_gap = quiet ? 0 : $urandom_range(0, 19);
        // One long hold-off so the core backs up and stalls its input.
        if (replies_seen == 300) recv_gap = 500;
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= 200000) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int vc, n, r;
    in_bus.valid = 1'b0;
    in_bus.cmd   = CMD_WR_OFFSET;
    in_bus.index = '0;
    in_bus.value = '0;
    out_bus.ready = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    for (int i = 0; i < MAX_V; i++) begin
      m_dist[i] = NONE16;
      m_par[i]  = NONE16;
      m_seen[i] = 1'b0;
    end
    for (int i = 0; i <= MAX_V; i++) begin
      m_off[i] = '0;
      g_off[i] = 0;
      g_off_ok[i] = 1'b0;
    end
    for (int i = 0; i < MAX_E; i++) begin
      m_adj[i] = '0;
      g_adj_ok[i] = 1'b0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset contents, ignored slots, a saturated edge range and
    // a self loop on a one-vertex graph.
    set_regs(1, 0);
    put(CMD_READ, 0, 0);
    put(CMD_READ, 8191, 8191);
    put(CMD_WR_OFFSET, 1025, 8191);
    put(CMD_WR_ADJ, 4096, 8191);
    put(CMD_WR_OFFSET, 0, 4095);
    put(CMD_WR_OFFSET, 1, 8191);
    put(CMD_WR_ADJ, 4095, 0);
    put(CMD_RUN, 0, 0);
    put(CMD_READ, 0, 0);
    put(CMD_READ, 1, 0);
    put(CMD_WR_OFFSET, 1024, 0);
    put(CMD_WR_ADJ, 0, 8191);
    drain();

    // Empty graph.
    set_regs(0, 0);
    put(CMD_RUN, 0, 0);
    put(CMD_READ, 0, 0);
    put(CMD_READ, 5, 0);
    drain();

    // Full size graph searched from the last vertex. Only the top vertices
    // are loaded, and their edges stay among them or leave the range.
    set_regs(1024, 1023);
    build_span(1000, 1024, 0);
    put(CMD_RUN, 0, 0);
    put(CMD_READ, 1023, 0);
    put(CMD_READ, 0, 0);
    put(CMD_READ, 1024, 0);
    for (int i = 0; i < 12; i++) put(CMD_READ, $urandom_range(990, 1023), 0);
    drain();

    // Oversized count saturates to the full vertex range.
    set_regs(2047, 1000);
    put(CMD_RUN, 0, 0);
    for (int i = 0; i < 8; i++) put(CMD_READ, $urandom_range(0, 1100), 0);
    drain();

    // Source beyond the vertex count, edge ranges past the table end.
    set_regs(5, 1023);
    build_graph(5, 4093);
    prep_run(5);
    put(CMD_READ, 0, 0);
    drain();

    for (int p = 5; p < 11; p++) begin
      quiet = (p % 4 == 3);
      vc = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 40);
      n = live_count(vc);
      set_regs(vc, ($urandom_range(0, 99) < 85) ? $urandom_range(0, n - 1)
                                                  : $urandom_range(0, 1023));
      build_graph(n, $urandom_range(0, 4090));
      prep_run(n);
      for (int i = 0; i < 50; i++) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          prep_run(n);
        end else if (r < 55) begin
          put(CMD_READ, ($urandom_range(0, 9) < 8) ? $urandom_range(0, n)
                                                   : $urandom_range(0, 8191),
              $urandom_range(0, 8191));
        end else if (r < 75) begin
          put(CMD_WR_ADJ, ($urandom_range(0, 9) < 9) ? $urandom_range(0, 4095)
                                                     : $urandom_range(4096, 8191),
              pick_nbr(n));
        end else if (r < 88) begin
          put(CMD_WR_OFFSET, ($urandom_range(0, 1) == 0) ? $urandom_range(1025, 8191)
                                                         : $urandom_range(0, 1024),
              $urandom_range(0, 8191));
        end else begin
          put(CMD_READ, m_src, 0);
        end
      end
      prep_run(n);
      for (int v = 0; v < n && v < 8; v++) put(CMD_READ, v, 0);
      drain();
    end

    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
